// ===== rtl/cwds_pkg.sv =====
// shared types, constants and the digit encoder for the display-select clock
// no dependencies; imported by clock_with_display_select_core
package cwds_pkg;

   localparam int unsigned TICK_W  = 10;
   localparam int unsigned BLINK_W = 10;
   localparam int unsigned PHASE_W = 8;
   localparam int unsigned CYCLE_W = 10;
   localparam int unsigned SEC_W   = 6;
   localparam int unsigned MIN_W   = 6;
   localparam int unsigned HOUR_W  = 5;
   localparam int unsigned SEG_W   = 7;
   localparam int unsigned CSR_W   = 10;
   localparam int unsigned ADDR_W  = 2;
   localparam int unsigned REQ_W   = 8;
   localparam int unsigned RSP_W   = 32;

   localparam logic [SEC_W-1:0]  SEC_LIMIT  = SEC_W'(60);
   localparam logic [MIN_W-1:0]  MIN_LIMIT  = MIN_W'(60);
   localparam logic [HOUR_W-1:0] HOUR_LIMIT = HOUR_W'(24);

   localparam logic [TICK_W-1:0]  TPS_RESET   = TICK_W'(100);
   localparam logic [BLINK_W-1:0] HALF_RESET  = BLINK_W'(50);
   localparam logic [PHASE_W-1:0] PHASE_RESET = PHASE_W'(50);

   typedef enum logic [ADDR_W-1:0] {
      REG_TICKS_PER_SECOND = 2'd0,
      REG_LED_HALF_PERIOD  = 2'd1,
      REG_PHASE_TICKS      = 2'd2
   } reg_index_type;

   typedef logic [SEG_W-1:0] seg_type;

   localparam seg_type SEG_CODE [10] = '{
      7'h3F, 7'h06, 7'h5B, 7'h4F, 7'h66, 7'h6D, 7'h7D, 7'h07, 7'h7F, 7'h67
   };

   typedef struct packed {
      logic [SEC_W-1:0]  seconds;
      logic [MIN_W-1:0]  minutes;
      logic [HOUR_W-1:0] hours;
      logic              led_on;
      seg_type           units_segments;
      seg_type           tens_segments;
   } rsp_type;

   // split a value below 64 into tens and units digits by compare chain
   function automatic logic [6:0] split_digits(input logic [SEC_W-1:0] value);
      logic [2:0] tens;
      logic [SEC_W-1:0] rest;
      tens = 3'd0;
      rest = value;
      for (int k = 6; k >= 1; k--) begin
         if (tens == 3'd0 && value >= SEC_W'(10 * k)) begin
            tens = 3'(k);
            rest = value - SEC_W'(10 * k);
         end
      end
      return {tens, rest[3:0]};
   endfunction

endpackage

// ===== rtl/clock_with_display_select_core.sv =====
// display-select clock: tick carries, led blink, display mux and segment encode
// depends on cwds_pkg
//
//   channel   | direction | payload
//   req_      | in        | tdata[0] sw_a, tdata[1] sw_b
//   rsp_      | out       | tdata: tens_segments, units_segments, led_on,
//             |           |        hours, minutes, seconds
//   csr_      | in        | we, addr (register index), wdata
//
// one tick is taken per cycle while the output is not stalled; its result is in
// the output register the next cycle. the state counters and the output register
// are the only stages; the carry chain and the segment lookup sit between them.
// reset is synchronous; it restores the register defaults and clears all counters.
// a stalled result holds the output register, and a new tick is taken in the same
// cycle the held result transfers.
module clock_with_display_select_core (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [cwds_pkg::REQ_W-1:0]          req_tdata,   // sw_a, sw_b
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // tens_segments, units_segments, led_on, hours, minutes, seconds
   output logic [cwds_pkg::RSP_W-1:0]          rsp_tdata,
   input  logic                                csr_we,
   input  logic [cwds_pkg::ADDR_W-1:0]         csr_addr,
   input  logic [cwds_pkg::CSR_W-1:0]          csr_wdata
);
   import cwds_pkg::*;

   logic [TICK_W-1:0]  tps_ff;
   logic [BLINK_W-1:0] half_ff;
   logic [PHASE_W-1:0] phase_ff;

   logic [TICK_W-1:0]  tick_ff, tick_in;
   logic [SEC_W-1:0]   sec_ff, sec_in;
   logic [MIN_W-1:0]   min_ff, min_in;
   logic [HOUR_W-1:0]  hour_ff, hour_in;
   logic [BLINK_W-1:0] blink_ff, blink_in;
   logic               led_ff, led_in;
   logic [CYCLE_W-1:0] cycle_ff, cycle_in;

   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_ff, rsp_in;

   logic               take;
   logic               sw_a, sw_b;
   logic [SEC_W-1:0]   shown;
   logic [6:0]         digits;
   logic [PHASE_W:0]   phase_x2;
   logic [CYCLE_W-1:0] phase_x3;
   logic [CYCLE_W-1:0] cycle_step;

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign take       = req_tvalid && req_tready;
   assign sw_a       = req_tdata[0];
   assign sw_b       = req_tdata[1];
   assign phase_x2   = {phase_ff, 1'b0};
   assign phase_x3   = CYCLE_W'({phase_ff, 1'b0}) + CYCLE_W'(phase_ff);

   always_comb begin
      tick_in    = tick_ff;
      sec_in     = sec_ff;
      min_in     = min_ff;
      hour_in    = hour_ff;
      blink_in   = blink_ff;
      led_in     = led_ff;
      cycle_step = cycle_ff;
      cycle_in   = cycle_ff;
      shown      = sec_ff;

      if (tick_ff >= tps_ff) begin
         tick_in = '0;
         sec_in  = sec_ff + SEC_W'(1);
      end
      if (sec_in >= SEC_LIMIT) begin
         sec_in = '0;
         min_in = min_ff + MIN_W'(1);
      end
      if (min_in >= MIN_LIMIT) begin
         min_in  = '0;
         hour_in = hour_ff + HOUR_W'(1);
      end
      if (hour_in >= HOUR_LIMIT) begin
         hour_in = '0;
      end

      if (blink_ff >= half_ff) begin
         blink_in = '0;
         led_in   = !led_ff;
      end

      case ({sw_a, sw_b})
         2'b00: shown = sec_in;
         2'b01: shown = SEC_W'(hour_in);
         2'b10: shown = min_in;
         default: begin
            if (cycle_ff < CYCLE_W'(phase_ff)) begin
               shown = sec_in;
            end else if (cycle_ff < CYCLE_W'(phase_x2)) begin
               shown = min_in;
            end else begin
               shown = SEC_W'(hour_in);
            end
            cycle_step = cycle_ff + CYCLE_W'(1);
         end
      endcase
      cycle_in = (cycle_step >= phase_x3) ? '0 : cycle_step;

      tick_in  = tick_in + TICK_W'(1);
      blink_in = blink_in + BLINK_W'(1);
   end

   assign digits = split_digits(shown);

   always_comb begin
      rsp_in.tens_segments  = SEG_CODE[{1'b0, digits[6:4]}];
      rsp_in.units_segments = SEG_CODE[digits[3:0]];
      rsp_in.led_on         = led_in;
      rsp_in.hours          = hour_in;
      rsp_in.minutes        = min_in;
      rsp_in.seconds        = sec_in;
      rsp_valid_in          = take || (rsp_valid_ff && !rsp_tready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tps_ff       <= TPS_RESET;
         half_ff      <= HALF_RESET;
         phase_ff     <= PHASE_RESET;
         tick_ff      <= '0;
         sec_ff       <= '0;
         min_ff       <= '0;
         hour_ff      <= '0;
         blink_ff     <= '0;
         led_ff       <= 1'b1;
         cycle_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            case (reg_index_type'(csr_addr))
               REG_TICKS_PER_SECOND: tps_ff   <= csr_wdata;
               REG_LED_HALF_PERIOD:  half_ff  <= csr_wdata;
               REG_PHASE_TICKS:      phase_ff <= csr_wdata[PHASE_W-1:0];
               default: ;
            endcase
         end
         if (take) begin
            tick_ff  <= tick_in;
            sec_ff   <= sec_in;
            min_ff   <= min_in;
            hour_ff  <= hour_in;
            blink_ff <= blink_in;
            led_ff   <= led_in;
            cycle_ff <= cycle_in;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_ff;

endmodule
